// File: sv/rdi_pkg.sv
package rdi_pkg;

	localparam int FRAC_DEF = 16;
	localparam int XW       = 32;
	localparam int TW       = 31;
	localparam int PW       = 64;
	localparam int QDEPTH   = 4;
	localparam int IDX_W    = 3;

	localparam logic [TW-1:0] T_MAX = {TW{1'b1}};

	typedef enum logic [IDX_W-1:0] {
		REG_NORMAL_X = 3'd0,
		REG_NORMAL_Y = 3'd1,
		REG_NORMAL_Z = 3'd2,
		REG_CENTER_X = 3'd3,
		REG_CENTER_Y = 3'd4,
		REG_CENTER_Z = 3'd5,
		REG_RADIUS_SQ = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][XW-1:0] normal;
		logic [2:0][XW-1:0] center;
		logic [XW-1:0]      radius_squared;
	} cfg_t;

	// one classified ray waiting for the divider
	typedef struct packed {
		logic               miss;
		logic [PW-1:0]      un;
		logic [PW-1:0]      ud;
		logic [2:0][XW-1:0] org;
		logic [2:0][XW-1:0] dir;
	} qitem_t;

endpackage

// File: sv/rdi_if.sv
interface rdi_ray_if;
	import rdi_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [XW-1:0] origin_x;
	logic signed [XW-1:0] origin_y;
	logic signed [XW-1:0] origin_z;
	logic signed [XW-1:0] dir_x;
	logic signed [XW-1:0] dir_y;
	logic signed [XW-1:0] dir_z;
	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface rdi_res_if;
	import rdi_pkg::*;
	logic          valid;
	logic          ready;
	logic          hit;
	logic [TW-1:0] distance;
	modport source (output valid, hit, distance, input ready);
	modport sink (input valid, hit, distance, output ready);
endinterface

// File: sv/rdi_front.sv
module rdi_front #(
	parameter int FRAC_BITS = rdi_pkg::FRAC_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	rdi_ray_if.sink         ray,
	input  rdi_pkg::cfg_t   cfg,
	output rdi_pkg::qitem_t item,
	output logic            item_valid,
	input  logic            item_ready
);
	import rdi_pkg::*;

	logic                 adv;
	logic                 vld_s1, vld_s2;
	logic signed [PW-1:0] pc_s1 [3];
	logic signed [PW-1:0] po_s1 [3];
	logic signed [PW-1:0] pd_s1 [3];
	logic [2:0][XW-1:0]   org_s1, dir_s1;
	qitem_t               item_s2;
	qitem_t               item_n;
	logic signed [PW-1:0] sc, so, sd, num, den;

	// the whole front moves as one; hold while the queue is full
	assign adv       = !vld_s2 || item_ready;
	assign ray.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= ray.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			org_s1 <= {ray.origin_z, ray.origin_y, ray.origin_x};
			dir_s1 <= {ray.dir_z, ray.dir_y, ray.dir_x};
			pc_s1[0] <= $signed(cfg.normal[0]) * $signed(cfg.center[0]);
			pc_s1[1] <= $signed(cfg.normal[1]) * $signed(cfg.center[1]);
			pc_s1[2] <= $signed(cfg.normal[2]) * $signed(cfg.center[2]);
			po_s1[0] <= $signed(cfg.normal[0]) * ray.origin_x;
			po_s1[1] <= $signed(cfg.normal[1]) * ray.origin_y;
			po_s1[2] <= $signed(cfg.normal[2]) * ray.origin_z;
			pd_s1[0] <= $signed(cfg.normal[0]) * ray.dir_x;
			pd_s1[1] <= $signed(cfg.normal[1]) * ray.dir_y;
			pd_s1[2] <= $signed(cfg.normal[2]) * ray.dir_z;
			item_s2  <= item_n;
		end
	end

	// arithmetic shift floors each product
	always_comb begin
		sc = (pc_s1[0] >>> FRAC_BITS) + (pc_s1[1] >>> FRAC_BITS) + (pc_s1[2] >>> FRAC_BITS);
		so = (po_s1[0] >>> FRAC_BITS) + (po_s1[1] >>> FRAC_BITS) + (po_s1[2] >>> FRAC_BITS);
		sd = (pd_s1[0] >>> FRAC_BITS) + (pd_s1[1] >>> FRAC_BITS) + (pd_s1[2] >>> FRAC_BITS);
		num = sc - so;
		den = sd;
		item_n.miss = (den == '0) || (num == '0) || (num[PW-1] != den[PW-1]);
		item_n.un   = num[PW-1] ? PW'(-num) : PW'(num);
		item_n.ud   = den[PW-1] ? PW'(-den) : PW'(den);
		item_n.org  = org_s1;
		item_n.dir  = dir_s1;
	end

	assign item       = item_s2;
	assign item_valid = vld_s2;

endmodule

// File: sv/rdi_queue.sv
module rdi_queue #(
	parameter int DEPTH = rdi_pkg::QDEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rdi_pkg::qitem_t wr_item,
	input  logic            wr_valid,
	output logic            wr_ready,
	output rdi_pkg::qitem_t rd_item,
	output logic            rd_valid,
	input  logic            rd_ready
);
	import rdi_pkg::*;

	localparam int AW = $clog2(DEPTH);

	qitem_t        mem [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;
	logic          push, pop;

	assign wr_ready = count_q != (AW+1)'(DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_item  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_item;
	end

endmodule

// File: sv/rdi_back.sv
module rdi_back #(
	parameter int FRAC_BITS = rdi_pkg::FRAC_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rdi_pkg::qitem_t item,
	input  logic            item_valid,
	output logic            item_ready,
	input  rdi_pkg::cfg_t   cfg,
	rdi_res_if.source       res
);
	import rdi_pkg::*;

	localparam int RW = PW + TW + 1;

	logic adv;

	// divider: stage 0 checks saturation, then one quotient bit per stage
	logic               dv_vld [TW+1];
	logic [RW-1:0]      rem_s  [TW+1];
	logic [TW-1:0]      quo_s  [TW+1];
	logic [PW-1:0]      ud_s   [TW+1];
	logic               miss_s [TW+1];
	logic               sat_s  [TW+1];
	logic [2:0][XW-1:0] org_s  [TW+1];
	logic [2:0][XW-1:0] dir_s  [TW+1];
	logic [RW-1:0]      dsh    [TW+1];
	logic               ge     [TW+1];

	logic [TW-1:0]        t_w;
	logic                 miss_w;
	logic                 vld_s1, vld_s2, vld_s3, vld_q;
	logic signed [PW-1:0] prod_s1 [3];
	logic [TW-1:0]        t_s1, t_s2, t_s3;
	logic                 miss_s1, miss_s2, miss_s3;
	logic [2:0][XW-1:0]   org_s1;
	logic [TW-1:0]        mag_s2 [3];
	logic                 far_s2, far_s3;
	logic [2*TW-1:0]      sq_s3 [3];
	logic                 hit_q;
	logic [TW-1:0]        dist_q;

	logic signed [PW-1:0] pnt, diff;
	logic [PW-1:0]        mag_w [3];
	logic                 far_w;
	logic [PW-1:0]        dsum;
	logic                 hit_w;

	assign adv        = !vld_q || res.ready;
	assign item_ready = adv;

	always_comb begin
		dsh[0] = '0;
		ge[0]  = 1'b0;
		for (int g = 1; g <= TW; g++) begin
			dsh[g] = RW'(ud_s[g-1]) << (TW - g);
			ge[g]  = rem_s[g-1] >= dsh[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g <= TW; g++)
				dv_vld[g] <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			dv_vld[0] <= item_valid;
			for (int g = 1; g <= TW; g++)
				dv_vld[g] <= dv_vld[g-1];
			vld_s1 <= dv_vld[TW];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_q  <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= RW'(item.un) << FRAC_BITS;
			sat_s[0]  <= (RW'(item.un) << FRAC_BITS) >= (RW'(item.ud) << TW);
			quo_s[0]  <= '0;
			ud_s[0]   <= item.ud;
			miss_s[0] <= item.miss;
			org_s[0]  <= item.org;
			dir_s[0]  <= item.dir;
			for (int g = 1; g <= TW; g++) begin
				rem_s[g]  <= ge[g] ? rem_s[g-1] - dsh[g] : rem_s[g-1];
				quo_s[g]  <= quo_s[g-1] | (ge[g] ? TW'(1) << (TW - g) : '0);
				ud_s[g]   <= ud_s[g-1];
				sat_s[g]  <= sat_s[g-1];
				miss_s[g] <= miss_s[g-1];
				org_s[g]  <= org_s[g-1];
				dir_s[g]  <= dir_s[g-1];
			end
		end
	end

	assign t_w    = sat_s[TW] ? T_MAX : quo_s[TW];
	assign miss_w = miss_s[TW] || (t_w == '0);

	// hit point offsets, distance to centre, squared distance
	always_comb begin
		far_w = 1'b0;
		pnt   = '0;
		diff  = '0;
		for (int i = 0; i < 3; i++) begin
			pnt  = PW'($signed(org_s1[i])) + (prod_s1[i] >>> FRAC_BITS);
			diff = pnt - PW'($signed(cfg.center[i]));
			mag_w[i] = diff[PW-1] ? PW'(-diff) : PW'(diff);
			far_w = far_w || (mag_w[i][PW-1:TW] != '0);
		end
		dsum = '0;
		for (int i = 0; i < 3; i++)
			dsum = dsum + PW'(sq_s3[i] >> FRAC_BITS);
		hit_w = !miss_s3 && !far_s3 && (dsum <= PW'(cfg.radius_squared));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				prod_s1[i] <= $signed(dir_s[TW][i]) * $signed({1'b0, t_w});
			t_s1    <= t_w;
			miss_s1 <= miss_w;
			org_s1  <= org_s[TW];

			for (int i = 0; i < 3; i++)
				mag_s2[i] <= mag_w[i][TW-1:0];
			far_s2  <= far_w;
			t_s2    <= t_s1;
			miss_s2 <= miss_s1;

			for (int i = 0; i < 3; i++)
				sq_s3[i] <= mag_s2[i] * mag_s2[i];
			far_s3  <= far_s2;
			t_s3    <= t_s2;
			miss_s3 <= miss_s2;

			hit_q  <= hit_w;
			dist_q <= hit_w ? t_s3 : '0;
		end
	end

	assign res.valid    = vld_q;
	assign res.hit      = hit_q;
	assign res.distance = dist_q;

endmodule

// File: sv/ray_disk_intersect.sv
// Pipeline: front stages s1 and s2, the queue, 32 divider stages, then back stages s1,
// s2 and s3 and the result register. Throughput: one ray per cycle while result.ready
// is high; the divider retires one quotient bit per stage.
// Reset (arst_n low, asynchronous) empties pipeline and queue and sets the disk
// to normal +z, centre at origin, radius squared 1.0.
module ray_disk_intersect #(
	parameter int FRAC_BITS = rdi_pkg::FRAC_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	rdi_ray_if.sink                   ray,
	rdi_res_if.source                 result,
	input  logic                      cfg_we,
	input  logic [rdi_pkg::IDX_W-1:0] cfg_index,
	input  logic [rdi_pkg::XW-1:0]    cfg_data
);
	import rdi_pkg::*;

	cfg_t   cfg_q;
	qitem_t f_item, b_item;
	logic   f_valid, f_ready, b_valid, b_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal[0]      <= '0;
			cfg_q.normal[1]      <= '0;
			cfg_q.normal[2]      <= XW'(1) << FRAC_BITS;
			cfg_q.center[0]      <= '0;
			cfg_q.center[1]      <= '0;
			cfg_q.center[2]      <= '0;
			cfg_q.radius_squared <= XW'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_NORMAL_X:  cfg_q.normal[0]      <= cfg_data;
				REG_NORMAL_Y:  cfg_q.normal[1]      <= cfg_data;
				REG_NORMAL_Z:  cfg_q.normal[2]      <= cfg_data;
				REG_CENTER_X:  cfg_q.center[0]      <= cfg_data;
				REG_CENTER_Y:  cfg_q.center[1]      <= cfg_data;
				REG_CENTER_Z:  cfg_q.center[2]      <= cfg_data;
				REG_RADIUS_SQ: cfg_q.radius_squared <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	rdi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ray        (ray),
		.cfg        (cfg_q),
		.item       (f_item),
		.item_valid (f_valid),
		.item_ready (f_ready)
	);

	rdi_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_item  (f_item),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_item  (b_item),
		.rd_valid (b_valid),
		.rd_ready (b_ready)
	);

	rdi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (b_item),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.cfg        (cfg_q),
		.res        (result)
	);

endmodule

// File: tb/tb.sv
module tb;
	import rdi_pkg::*;

	localparam int F = FRAC_DEF;
	localparam int WATCHDOG = 20000;
	localparam int DRAIN = 60;
	localparam int N_PHASE = 6;
	localparam int PER_PHASE = 280;
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [XW-1:0] ox, oy, oz, dx, dy, dz;
	} ray_t;

	typedef struct packed {
		logic          hit;
		logic [TW-1:0] dval;
	} hit_t;

	typedef struct packed {
		ray_t r;
		logic typed;
		hit_t want;
	} row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [XW-1:0] cfg_data;

	rdi_ray_if ray();
	rdi_res_if result();

	ray_disk_intersect dut (
		.clk(clk), .arst_n(arst_n), .ray(ray), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [XW-1:0] disk_reg [7];
	hit_t pending [$];
	int errors = 0, n_sent = 0, n_got = 0, n_hits = 0, idle_cnt = 0;
	int src_idle = 0, snk_idle = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic longint sx(logic [XW-1:0] v);
		return longint'($signed(v));
	endfunction

	function automatic hit_t predict_hit(ray_t r);
		longint n[3], c[3], o[3], d[3];
		longint num, den, un, ud, ip, t, p, df, m;
		logic [127:0] q;
		longint unsigned dsq;
		hit_t h;
		h = '0;
		for (int i = 0; i < 3; i++) begin
			n[i] = sx(disk_reg[i]);
			c[i] = sx(disk_reg[3+i]);
		end
		o[0] = sx(r.ox); o[1] = sx(r.oy); o[2] = sx(r.oz);
		d[0] = sx(r.dx); d[1] = sx(r.dy); d[2] = sx(r.dz);
		num = 0; den = 0;
		for (int i = 0; i < 3; i++) begin
			num += ((n[i] * c[i]) >>> F) - ((n[i] * o[i]) >>> F);
			den += (n[i] * d[i]) >>> F;
		end
		if (den == 0 || num == 0 || ((num < 0) != (den < 0)))
			return h;
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		ip = un / ud;
		if (ip > (longint'(T_MAX) >> F)) begin
			t = longint'(T_MAX);
		end else begin
			q = ({64'd0, un} << F) / {64'd0, ud};
			t = longint'(q[63:0]);
		end
		if (t == 0)
			return h;
		dsq = 0;
		for (int i = 0; i < 3; i++) begin
			p = o[i] + ((d[i] * t) >>> F);
			df = p - c[i];
			m = df < 0 ? -df : df;
			if (m >= 64'h8000_0000)
				return h;
			dsq += longint'(m * m) >> F;
		end
		if (dsq <= {32'd0, disk_reg[6]}) begin
			h.hit = 1'b1;
			h.dval = t[TW-1:0];
		end
		return h;
	endfunction

	// result side: check, stall, watchdog
	always @(posedge clk) begin
		hit_t w;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				n_got++;
				if (result.hit) n_hits++;
				if (pending.size() == 0) begin
					errors++;
					$display("%0t: unexpected result hit=%0b distance=%0h", $time,
						result.hit, result.distance);
				end else begin
					w = pending.pop_front();
					if (w.hit !== result.hit) begin
						errors++;
						$display("%0t: hit expected %0b actual %0b", $time, w.hit, result.hit);
					end
					if (w.dval !== result.distance) begin
						errors++;
						$display("%0t: distance expected %0h actual %0h", $time, w.dval,
							result.distance);
					end
				end
			end
			if ((result.valid && result.ready) || (ray.valid && ray.ready))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= WATCHDOG) begin
				$display("tb: failure");
				$finish;
			end
		end
		result.ready <= ($urandom_range(99) >= snk_idle);
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [XW-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		if (idx != REG_UNUSED)
			disk_reg[idx] = v;
	endtask

	task automatic set_disk(input longint nx, ny, nz, cx, cy, cz, r2);
		write_reg(REG_NORMAL_X, XW'(nx));
		write_reg(REG_NORMAL_Y, XW'(ny));
		write_reg(REG_NORMAL_Z, XW'(nz));
		write_reg(REG_CENTER_X, XW'(cx));
		write_reg(REG_CENTER_Y, XW'(cy));
		write_reg(REG_CENTER_Z, XW'(cz));
		write_reg(REG_RADIUS_SQ, XW'(r2));
		// write to the unused index must be dropped
		write_reg(REG_UNUSED, $urandom);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_ray(input ray_t r, input logic typed, input hit_t want);
		while ($urandom_range(99) < src_idle) begin
			ray.valid <= 1'b0;
			@(posedge clk);
		end
		ray.valid <= 1'b1;
		{ray.origin_x, ray.origin_y, ray.origin_z, ray.dir_x, ray.dir_y, ray.dir_z} <= r;
		@(posedge clk);
		while (!ray.ready) @(posedge clk);
		pending.push_back(typed ? want : predict_hit(r));
		n_sent++;
		if (n_sent == 600) begin
			src_idle = 60; snk_idle = 8;
		end else if (n_sent == 1200) begin
			src_idle = 0; snk_idle = 0;
		end
	endtask

	task automatic drain;
		ray.valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic longint srange(int lim);
		return longint'($urandom_range(2 * lim)) - lim;
	endfunction

	// aim a ray at a point near the disk centre
	function automatic ray_t aimed_ray();
		longint d[3], p[3], t0;
		ray_t r;
		t0 = $urandom_range(1 << 20, 1);
		for (int i = 0; i < 3; i++) begin
			d[i] = srange(1 << 18);
			p[i] = sx(disk_reg[3+i]) + srange(1 << 15);
		end
		r.dx = XW'(d[0]); r.dy = XW'(d[1]); r.dz = XW'(d[2]);
		r.ox = XW'(p[0] - ((d[0] * t0) >>> F));
		r.oy = XW'(p[1] - ((d[1] * t0) >>> F));
		r.oz = XW'(p[2] - ((d[2] * t0) >>> F));
		return r;
	endfunction

	initial begin
		row_t rows [$];
		row_t rw;
		ray_t r;
		hit_t none;
		none = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ray.valid = 1'b0;
		{ray.origin_x, ray.origin_y, ray.origin_z, ray.dir_x, ray.dir_y, ray.dir_z} = '0;
		foreach (disk_reg[i]) disk_reg[i] = '0;
		disk_reg[REG_NORMAL_Z] = 32'h0001_0000;
		disk_reg[REG_RADIUS_SQ] = 32'h0001_0000;
		src_idle = 8; snk_idle = 60;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// straight down onto the centre from height one
		rows.push_back('{'{0, 0, 32'h1_0000, 0, 0, 32'hFFFF_0000}, 1'b1, '{1'b1, 31'h1_0000}});
		// parallel to the plane
		rows.push_back('{'{0, 0, 32'h1_0000, 32'h1_0000, 0, 0}, 1'b1, none});
		// zero direction
		rows.push_back('{'{0, 0, 32'h1_0000, 0, 0, 0}, 1'b1, none});
		// plane behind the origin
		rows.push_back('{'{0, 0, 32'hFFFF_0000, 0, 0, 32'hFFFF_0000}, 1'b1, none});
		// origin on the plane
		rows.push_back('{'{0, 0, 0, 0, 0, 32'h1_0000}, 1'b1, none});
		// t truncates to zero
		rows.push_back('{'{0, 0, 32'h0000_0001, 0, 0, 32'h8000_0000}, 1'b1, none});
		// large t saturates, far point
		rows.push_back('{'{0, 0, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF}, 1'b0, none});
		rows.push_back('{'{0, 0, 32'h0001_0000, 0, 0, 32'hFFFF_FFFF}, 1'b0, none});
		// just outside and on the rim
		rows.push_back('{'{32'h1_0000, 0, 32'h1_0000, 0, 0, 32'hFFFF_0000}, 1'b0, none});
		rows.push_back('{'{32'h1_0001, 0, 32'h1_0000, 0, 0, 32'hFFFF_0000}, 1'b0, none});
		rows.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, none});
		rows.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, none});
		rows.push_back('{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, none});
		rows.push_back('{'{0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF}, 1'b0, none});
		rows.push_back('{'{32'h8000, 32'h8000, 32'h2_0000, 0, 0, 32'hFFFF_8000}, 1'b0, none});
		foreach (rows[i]) begin
			rw = rows[i];
			send_ray(rw.r, rw.typed, rw.want);
		end
		drain();

		for (int ph = 0; ph < N_PHASE; ph++) begin
			case (ph)
				0: set_disk(0, 0, 32'h1_0000, srange(1 << 20), srange(1 << 20), srange(1 << 20),
					$urandom_range(1 << 22));
				1: set_disk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
				2: set_disk(srange(1 << 17), srange(1 << 17), srange(1 << 17),
					srange(1 << 20), srange(1 << 20), srange(1 << 20), $urandom_range(1 << 24));
				3: set_disk(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
				4: set_disk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 32'hFFFF_FFFF);
				default: set_disk($urandom, $urandom, srange(1 << 18), srange(1 << 20),
					srange(1 << 20), srange(1 << 20), $urandom);
			endcase
			for (int k = 0; k < PER_PHASE; k++) begin
				if ($urandom_range(99) < 75)
					r = aimed_ray();
				else
					r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
				send_ray(r, 1'b0, none);
			end
			// hold the sender until everything is back
			drain();
		end

		$display("tb: %0d rays sent, %0d results checked, %0d hits, %0d disk settings",
			n_sent, n_got, n_hits, N_PHASE + 1);
		$display("tb: idling on both sides, extreme and zero normals, saturated t covered");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// File: files.f
sv/rdi_pkg.sv
sv/rdi_if.sv
sv/rdi_front.sv
sv/rdi_queue.sv
sv/rdi_back.sv
sv/ray_disk_intersect.sv
tb/tb.sv
